[src/ovt_pkg.sv]
// Shared types and codes for the object version table.
package ovt_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_COMMIT = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADMODE = 2'd2;

  localparam logic [31:0] VERSION_NEW     = 32'd1;
  localparam logic [31:0] COMMIT_SUCCESS  = 32'd0;
  localparam logic [31:0] COMMIT_CONFLICT = 32'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] object_key;
    logic [31:0] commit_version;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } rsp_t;

  // A lookup walking the row of cells, one cell per cycle.
  typedef struct packed {
    logic        active;
    logic [1:0]  mode;
    logic [31:0] object_key;
    logic [31:0] commit_version;
    logic        hit;
    logic        inserted;
    logic [31:0] value;
  } probe_t;

endpackage

[src/ovt_cell.sv]
// One table slot: holds a key and its version and serves the probe passing through.
module ovt_cell #(
  parameter int CW    = 7,
  parameter int INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [CW-1:0]   entry_count,
  input  ovt_pkg::probe_t probe_in,
  output ovt_pkg::probe_t probe_out
);
  import ovt_pkg::*;

  logic [31:0] key;
  logic [31:0] version;
  logic [31:0] key_next;
  logic [31:0] version_next;
  logic        occupied;
  logic        match;
  probe_t      probe_next;

  assign occupied = CW'(INDEX) < entry_count;
  assign match    = occupied && (key == probe_in.object_key);

  always_comb begin
    probe_next   = probe_in;
    key_next     = key;
    version_next = version;
    if (probe_in.active && !probe_in.hit) begin
      if (match) begin
        probe_next.hit = 1'b1;
        if (probe_in.mode == MODE_GET) begin
          probe_next.value = version;
        end else if (probe_in.commit_version == version) begin
          probe_next.value = COMMIT_SUCCESS;
          version_next     = version + 32'd1;
        end else begin
          probe_next.value = COMMIT_CONFLICT;
        end
      end else if (!occupied && probe_in.mode == MODE_GET) begin
        // Slots fill in order, so the first free slot sees the probe after every occupied one.
        key_next            = probe_in.object_key;
        version_next        = VERSION_NEW;
        probe_next.hit      = 1'b1;
        probe_next.inserted = 1'b1;
        probe_next.value    = VERSION_NEW;
      end
    end
  end

  always_ff @(posedge clk) begin
    key       <= key_next;
    version   <= version_next;
    probe_out <= probe_next;
    if (rst) begin
      probe_out.active <= 1'b0;
    end
  end

endmodule

[src/object_version_table.sv]
// Top level of the object version table: request handling and the row of slot cells.
//
//   channel | signals                        | word
//   req     | req_valid, req_stall, req      | mode, object_key, commit_version
//   rsp     | rsp_valid, rsp_stall, rsp      | value, status
//
// Start and unsupported requests are written straight into the output register on acceptance.
// Get-version and commit walk the row of TABLE_ENTRIES cells one cell per cycle, held in the
// head register, each cell and the output register; one request is in flight at once.
// Reset clears the slot count, the transaction counter and all control flags.
// A stalled result holds the output register, and no request is taken until it is gone.
module object_version_table #(
  parameter int TABLE_ENTRIES = ovt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ovt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ovt_pkg::rsp_t rsp
);
  import ovt_pkg::*;

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic                   busy;
  logic [CW-1:0]          entry_count;
  logic [31:0]            txn_counter;
  logic [31:0]            txn_next;
  logic                   accept;
  logic                   lookup;
  probe_t                 head;
  probe_t                 link [TABLE_ENTRIES+1];
  probe_t                 tail;
  logic [TABLE_ENTRIES:0] act;
  rsp_t                   miss_rsp;

  assign req_stall = busy || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign lookup    = (req.mode == MODE_GET) || (req.mode == MODE_COMMIT);
  assign txn_next  = txn_counter + 32'd1;
  assign link[0]   = head;
  assign tail      = link[TABLE_ENTRIES];

  genvar g;
  for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    ovt_cell #(
      .CW   (CW),
      .INDEX(g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .entry_count(entry_count),
      .probe_in   (link[g]),
      .probe_out  (link[g+1])
    );
  end

  for (g = 0; g <= TABLE_ENTRIES; g++) begin : g_act
    assign act[g] = link[g].active;
  end

  always_comb begin
    miss_rsp.status = ST_OK;
    miss_rsp.value  = COMMIT_SUCCESS;
    if (tail.mode == MODE_GET) begin
      miss_rsp.status = ST_FULL;
      miss_rsp.value  = 32'd0;
    end else if (tail.commit_version != 32'd0) begin
      miss_rsp.value = COMMIT_CONFLICT;
    end
  end

  always_ff @(posedge clk) begin
    head.active         <= accept && lookup;
    head.mode           <= req.mode;
    head.object_key     <= req.object_key;
    head.commit_version <= req.commit_version;
    head.hit            <= 1'b0;
    head.inserted       <= 1'b0;
    head.value          <= 32'd0;

    if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end

    if (accept) begin
      case (req.mode)
        MODE_START: begin
          txn_counter <= txn_next;
          rsp.value   <= txn_next;
          rsp.status  <= ST_OK;
          rsp_valid   <= 1'b1;
        end
        MODE_GET, MODE_COMMIT: begin
          busy <= 1'b1;
        end
        default: begin
          rsp.value  <= 32'd0;
          rsp.status <= ST_BADMODE;
          rsp_valid  <= 1'b1;
        end
      endcase
    end

    if (tail.active) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b1;
      if (tail.hit) begin
        rsp.value  <= tail.value;
        rsp.status <= ST_OK;
      end else begin
        rsp <= miss_rsp;
      end
      if (tail.inserted) begin
        entry_count <= entry_count + CW'(1);
      end
    end

    if (rst) begin
      head.active <= 1'b0;
      busy        <= 1'b0;
      rsp_valid   <= 1'b0;
      entry_count <= '0;
      txn_counter <= '0;
    end
  end

  a_one_probe: assert property (@(posedge clk) disable iff (rst) $onehot0(act))
    else $error("more than one lookup in the row of cells");

  a_tail_busy: assert property (@(posedge clk) disable iff (rst) tail.active |-> busy)
    else $error("lookup left the row while the block was not busy");

  a_tail_free: assert property (@(posedge clk) disable iff (rst) tail.active |-> !rsp_valid)
    else $error("lookup finished while the output register was occupied");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_ENTRIES))
    else $error("slot count exceeds the table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (entry_count == $past(entry_count)) ||
                    (entry_count == $past(entry_count) + CW'(1)))
    else $error("slot count moved by more than one");

endmodule

[verif/object_version_table_test.sv]
// Self-checking testbench for the object version table: directed and random requests.
module object_version_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ovt_pkg::*;

  localparam int SLOTS = TABLE_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int WORDS_PER_PHASE = 410;
  localparam int FRESH_KEY_PCT = 20;
  localparam logic [1:0] MODE_UNSUPPORTED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  req_t pending_words[$];
  rsp_t expected_answers[$];

  logic [31:0] table_keys [SLOTS];
  logic [31:0] table_versions [SLOTS];
  int table_fill = 0;
  logic [31:0] txn_count = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int words_taken = 0;
  int answers_checked = 0;
  int failures = 0;
  int starts_seen = 0, gets_seen = 0, inserts_seen = 0, full_seen = 0;
  int commits_seen = 0, conflicts_seen = 0, unsupported_seen = 0;

  object_version_table uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int find_entry(logic [31:0] key);
    for (int i = 0; i < table_fill; i++) begin
      if (table_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic rsp_t predict_answer(req_t r);
    rsp_t answer;
    int slot;
    logic [31:0] stored;
    answer.value = '0;
    answer.status = ST_OK;
    slot = find_entry(r.object_key);
    case (r.mode)
      MODE_START: begin
        txn_count = txn_count + 32'd1;
        answer.value = txn_count;
        starts_seen++;
      end
      MODE_GET: begin
        gets_seen++;
        if (slot >= 0) begin
          answer.value = table_versions[slot];
        end else if (table_fill < SLOTS) begin
          table_keys[table_fill] = r.object_key;
          table_versions[table_fill] = VERSION_NEW;
          table_fill++;
          answer.value = VERSION_NEW;
          inserts_seen++;
        end else begin
          answer.status = ST_FULL;
          full_seen++;
        end
      end
      MODE_COMMIT: begin
        commits_seen++;
        stored = (slot >= 0) ? table_versions[slot] : '0;
        if (r.commit_version == stored) begin
          if (slot >= 0) table_versions[slot] = stored + 32'd1;
          answer.value = COMMIT_SUCCESS;
        end else begin
          answer.value = COMMIT_CONFLICT;
          conflicts_seen++;
        end
      end
      default: begin
        answer.status = ST_BADMODE;
        unsupported_seen++;
      end
    endcase
    return answer;
  endfunction

  task automatic add_request(logic [1:0] mode, logic [31:0] key, logic [31:0] version);
    req_t r;
    r.mode = mode;
    r.object_key = key;
    r.commit_version = version;
    pending_words.push_back(r);
    expected_answers.push_back(predict_answer(r));
  endtask

  task automatic add_random_request();
    logic [1:0] mode;
    logic [31:0] key, version, current;
    int pick, slot;
    pick = $urandom_range(99);
    if (pick < 15) mode = MODE_START;
    else if (pick < 50) mode = MODE_GET;
    else if (pick < 92) mode = MODE_COMMIT;
    else mode = MODE_UNSUPPORTED;
    key = $urandom;
    version = $urandom;
    if (table_fill > 0 && $urandom_range(99) >= FRESH_KEY_PCT)
      key = table_keys[$urandom_range(table_fill - 1)];
    if (mode == MODE_COMMIT) begin
      slot = find_entry(key);
      current = (slot >= 0) ? table_versions[slot] : '0;
      pick = $urandom_range(99);
      if (pick < 60) version = current;
      else if (pick < 75) version = '0;
      else if (pick < 90) version = $urandom_range(1) ? current + 32'd1 : current - 32'd1;
    end
    add_request(mode, key, version);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || expected_answers.size() > 0) @(posedge clk);
  endtask

  task automatic note_mismatch(string what, rsp_t wanted, rsp_t got);
    failures++;
    if (failures <= 10)
      $display("%s at cycle %0d: expected value %h status %0d, got value %h status %0d",
               what, cycle_count, wanted.value, wanted.status, got.value, got.status);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) words_taken++;
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req <= pending_words.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    rsp_t wanted;
    if (!rst && rsp_valid && !rsp_stall) begin
      answers_checked++;
      if (expected_answers.size() == 0) begin
        wanted = '0;
        note_mismatch("Unexpected word", wanted, rsp);
      end else begin
        wanted = expected_answers.pop_front();
        if (rsp.value !== wanted.value || rsp.status !== wanted.status)
          note_mismatch("Mismatch", wanted, rsp);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding",
               cycle_count, expected_answers.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int idle_plan [4];
    int stall_plan [4];
    idle_plan = '{0, 75, 0, 24};
    stall_plan = '{0, 0, 75, 24};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_request(MODE_START, 32'h0000_0000, 32'h0000_0000);
    add_request(MODE_UNSUPPORTED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(MODE_UNSUPPORTED, 32'h0000_0000, 32'h0000_0000);
    add_request(MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    add_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    add_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
    add_request(MODE_COMMIT, 32'h0000_0000, 32'h0000_0001);
    add_request(MODE_COMMIT, 32'h0000_0000, 32'h0000_0001);
    add_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
    add_request(MODE_COMMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(MODE_COMMIT, 32'hFFFF_FFFF, 32'h0000_0001);
    add_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    add_request(MODE_COMMIT, 32'h1234_5678, 32'h0000_0000);
    add_request(MODE_COMMIT, 32'h1234_5678, 32'hFFFF_FFFF);
    add_request(MODE_GET, 32'h1234_5678, 32'h0000_0000);
    add_request(MODE_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(MODE_START, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_plan[phase];
      stall_pct = stall_plan[phase];
      for (int n = 0; n < WORDS_PER_PHASE; n++) add_random_request();
      drain();
    end

    stall_pct = 0;
    repeat (SLOTS + 8) @(posedge clk);
    $display("Run covered %0d request words and %0d result words over %0d cycles.",
             words_taken, answers_checked, cycle_count);
    $display("Starts %0d, gets %0d (inserts %0d, full %0d), commits %0d (conflicts %0d), other %0d.",
             starts_seen, gets_seen, inserts_seen, full_seen, commits_seen, conflicts_seen,
             unsupported_seen);
    if (failures == 0 && expected_answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d words still expected", failures, expected_answers.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
src/ovt_pkg.sv
src/ovt_cell.sv
src/object_version_table.sv
verif/object_version_table_test.sv
